### hdl/rbba_pkg.sv
// Package for the reference-counted bump block allocator.
// Holds the request and result beat types, status codes and sequencer states.
// No dependencies.
package rbba_pkg;

  // Field widths fixed by the request and result formats
  localparam int unsigned SIZE_IN_W = 16;
  localparam int unsigned SIZE_W    = 17;   // rounded size can reach 65536
  localparam int unsigned ADDR_W    = 18;
  localparam int unsigned USE_W     = 16;

  localparam logic [SIZE_W-1:0] ROUND_MASK = SIZE_W'(15);
  localparam logic [USE_W-1:0]  USE_MAX    = '1;

  // Request kinds
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_SLOT   = 2'd1,
    STAT_TOO_BIG   = 2'd2,
    STAT_NOT_ALLOC = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic                 action;
    logic [SIZE_IN_W-1:0] alloc_size;
    logic [ADDR_W-1:0]    free_address;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] result_address;
    logic              block_released;
  } rsp_t;

endpackage

### hdl/refcounted_bump_block_allocator_unit.sv
// Reference-counted bump block allocator: top level.
// A request beat is taken only while idle. The sequencer then scans every slot,
// reading one slot entry per cycle from the single-port fill/count memory, and
// commits once the result register is free; no new request is taken before that.
// Reset: all slots empty (live bits and ranks cleared); the memory is not swept,
// since an entry is always written when its slot opens. Depends on rbba_pkg.
module refcounted_bump_block_allocator_unit
  import rbba_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES = 32768,
  parameter int unsigned NUM_BLOCKS  = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  localparam int unsigned IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CNT_W  = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned FILL_W = $clog2(BLOCK_BYTES + 1);
  localparam int unsigned CW     = ((FILL_W > SIZE_W) ? FILL_W : SIZE_W) + 1;
  localparam int unsigned AW_RAW = $clog2(NUM_BLOCKS * BLOCK_BYTES + 1);
  localparam int unsigned AW     = (AW_RAW > ADDR_W) ? AW_RAW : ADDR_W;
  localparam int unsigned MEM_W  = USE_W + FILL_W;

  localparam logic [CW-1:0] BB_C = CW'(BLOCK_BYTES);
  localparam logic [AW-1:0] BB_A = AW'(BLOCK_BYTES);

  state_e state_q, state_d;

  req_t              req_q;
  logic [SIZE_W-1:0] size_q;
  logic [CNT_W-1:0]  scan_cnt_q;
  logic              eval_valid_q;
  logic [IDX_W-1:0]  eval_idx_q;

  logic              found_q;
  logic [IDX_W-1:0]  hit_idx_q;
  logic [IDX_W-1:0]  best_rank_q;
  logic [FILL_W-1:0] hit_fill_q;
  logic [USE_W-1:0]  hit_use_q;

  logic [NUM_BLOCKS-1:0] live_q;
  logic [IDX_W-1:0]      rank_q [NUM_BLOCKS];

  logic [MEM_W-1:0] mem_q [NUM_BLOCKS];
  logic [MEM_W-1:0] rd_data_q;

  logic       out_valid_q;
  rsp_t       out_q;

  logic in_fire, scan_last, rd_en, commit_go;

  // Sequencer: state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign scan_last = (scan_cnt_q == CNT_W'(NUM_BLOCKS));
  assign in_fire   = in_valid_i && in_ready_o;

  // Sequencer: next state and strobes
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    commit_go  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en = !scan_last;
        if (scan_last) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        commit_go = !out_valid_q || out_ready_i;
        if (commit_go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Capture the request and round its size up to 16 bytes
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q  <= in_data_i;
      size_q <= (SIZE_W'(in_data_i.alloc_size) + ROUND_MASK) & ~ROUND_MASK;
    end
  end

  // Scan counter and read pipeline tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q   <= '0;
      eval_valid_q <= 1'b0;
      eval_idx_q   <= '0;
    end else begin
      if (in_fire) begin
        scan_cnt_q <= '0;
      end else if (rd_en) begin
        scan_cnt_q <= scan_cnt_q + CNT_W'(1);
      end
      eval_valid_q <= rd_en;
      eval_idx_q   <= scan_cnt_q[IDX_W-1:0];
    end
  end

  // Evaluate the entry that came back from memory
  logic [FILL_W-1:0] ev_fill;
  logic [USE_W-1:0]  ev_use;
  logic [IDX_W-1:0]  ev_rank;
  logic              ev_fit, ev_hit, ev_take;
  logic [AW-1:0]     ev_base, ev_addr;

  always_comb begin
    ev_fill = rd_data_q[FILL_W-1:0];
    ev_use  = rd_data_q[MEM_W-1:FILL_W];
    ev_rank = rank_q[eval_idx_q];
    ev_base = AW'(eval_idx_q) * BB_A;
    ev_addr = AW'(req_q.free_address);
    ev_fit  = live_q[eval_idx_q] && ((CW'(size_q) + CW'(ev_fill)) <= BB_C);
    ev_hit  = live_q[eval_idx_q] && (ev_addr >= ev_base)
              && (ev_addr < (ev_base + AW'(ev_fill)));
    if (req_q.action == ACT_ALLOC) begin
      ev_take = ev_fit && (!found_q || (ev_rank < best_rank_q));
    end else begin
      ev_take = ev_hit && !found_q;
    end
  end

  // Hold the best candidate seen so far
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (in_fire) begin
      found_q <= 1'b0;
    end else if (eval_valid_q && ev_take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_valid_q && ev_take) begin
      hit_idx_q   <= eval_idx_q;
      best_rank_q <= ev_rank;
      hit_fill_q  <= ev_fill;
      hit_use_q   <= ev_use;
    end
  end

  // Lowest empty slot
  logic             empty_any;
  logic [IDX_W-1:0] empty_idx;

  always_comb begin
    empty_any = 1'b0;
    empty_idx = '0;
    for (int s = NUM_BLOCKS - 1; s >= 0; s--) begin
      if (!live_q[s]) begin
        empty_any = 1'b1;
        empty_idx = IDX_W'(s);
      end
    end
  end

  // Commit decision
  status_e           cm_status;
  logic [IDX_W-1:0]  cm_idx;
  logic [FILL_W-1:0] cm_fill;
  logic [USE_W-1:0]  cm_use;
  logic              cm_open, cm_release, cm_wr;
  logic [MEM_W-1:0]  cm_wdata;
  logic [AW-1:0]     cm_addr;
  logic [USE_W-1:0]  cm_use_dec;

  always_comb begin
    cm_status  = STAT_OK;
    cm_idx     = hit_idx_q;
    cm_fill    = hit_fill_q;
    cm_use     = hit_use_q;
    cm_open    = 1'b0;
    cm_release = 1'b0;
    cm_wr      = 1'b0;
    cm_wdata   = '0;
    cm_addr    = '0;
    cm_use_dec = (hit_use_q != '0) ? (hit_use_q - USE_W'(1)) : '0;
    if (req_q.action == ACT_ALLOC) begin
      if (CW'(size_q) > BB_C) begin
        cm_status = STAT_TOO_BIG;
      end else if (!found_q && !empty_any) begin
        cm_status = STAT_NO_SLOT;
      end else begin
        if (!found_q) begin
          cm_open = 1'b1;
          cm_idx  = empty_idx;
          cm_fill = '0;
          cm_use  = '0;
        end
        cm_wr    = 1'b1;
        cm_addr  = (AW'(cm_idx) * BB_A) + AW'(cm_fill);
        cm_wdata = {((cm_use != USE_MAX) ? (cm_use + USE_W'(1)) : cm_use),
                    FILL_W'(CW'(cm_fill) + CW'(size_q))};
      end
    end else begin
      if (!found_q) begin
        cm_status = STAT_NOT_ALLOC;
      end else begin
        cm_wr      = 1'b1;
        cm_release = (cm_use_dec == '0);
        cm_wdata   = {cm_use_dec, hit_fill_q};
      end
    end
  end

  // Fill/count memory: one read or one write per cycle
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[scan_cnt_q[IDX_W-1:0]];
    end
    if (commit_go && cm_wr) begin
      mem_q[cm_idx] <= cm_wdata;
    end
  end

  // Live bits and recency ranks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
      for (int s = 0; s < NUM_BLOCKS; s++) begin
        rank_q[s] <= '0;
      end
    end else if (commit_go) begin
      if (cm_open) begin
        for (int s = 0; s < NUM_BLOCKS; s++) begin
          if (live_q[s]) begin
            rank_q[s] <= rank_q[s] + IDX_W'(1);
          end
        end
        live_q[cm_idx] <= 1'b1;
        rank_q[cm_idx] <= '0;
      end else if (cm_release) begin
        for (int s = 0; s < NUM_BLOCKS; s++) begin
          if (live_q[s] && (rank_q[s] > rank_q[cm_idx])) begin
            rank_q[s] <= rank_q[s] - IDX_W'(1);
          end
        end
        live_q[cm_idx] <= 1'b0;
        rank_q[cm_idx] <= '0;
      end
    end
  end

  // Result register: load on commit, drop when the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_go) begin
      out_q.status         <= cm_status;
      out_q.result_address <= cm_addr[ADDR_W-1:0];
      out_q.block_released <= cm_release;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_idle_no_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !eval_valid_q && !rd_en)
    else $error("read pipeline busy while idle");

  a_scan_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_SCAN) && (scan_cnt_q == '0) && !found_q)
    else $error("scan did not restart after request beat");

  a_live_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit_go |=> $stable(live_q))
    else $error("slot live bits changed outside commit");

  a_open_sets_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit_go && cm_open) |=> live_q[$past(cm_idx)]
      && (rank_q[$past(cm_idx)] == '0))
    else $error("opened slot not live and newest");

endmodule
